// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int unsigned CASE_W = 2;

  typedef enum logic [CASE_W-1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_e;

endpackage

// ===== design/rmq_if.sv =====
`timescale 1ns / 1ps
interface rmq_in_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] row0_col0;
  logic signed [DATA_WIDTH-1:0] row0_col1;
  logic signed [DATA_WIDTH-1:0] row0_col2;
  logic signed [DATA_WIDTH-1:0] row1_col0;
  logic signed [DATA_WIDTH-1:0] row1_col1;
  logic signed [DATA_WIDTH-1:0] row1_col2;
  logic signed [DATA_WIDTH-1:0] row2_col0;
  logic signed [DATA_WIDTH-1:0] row2_col1;
  logic signed [DATA_WIDTH-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

interface rmq_out_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  import rmq_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic [CASE_W-1:0]            case_used;
  logic                         bad_radicand;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, case_used, bad_radicand,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, case_used, bad_radicand,
    output ready
  );
endinterface

// ===== design/rotation_matrix_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// throughput: one matrix per cycle while the output is not stalled; one square root bit and one quotient bit per stage
// the whole pipeline advances together and holds while the output transfer is stalled
// reset: asynchronous, active low, clears the stage and output valid bits only
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned RB   = ((DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1) + 3;
  localparam int unsigned SQ   = (RB + FRAC_BITS) / 2;
  localparam int unsigned RWE  = 2 * SQ;
  localparam int unsigned SRW  = SQ + 3;
  localparam int unsigned DRW  = SQ + 2;
  localparam int unsigned NW   = DW + 1 + FRAC_BITS;
  localparam int unsigned MW   = ((NW > SQ) ? NW : SQ) + 1;
  localparam int unsigned LAST = SQ + NW;

  typedef struct packed {
    case_e                   sel;
    logic                    bad;
    logic [RWE-1:0]          rad;
    logic [SQ-1:0]           root;
    logic [SRW-1:0]          srem;
    logic [2:0]              neg;
    logic [2:0][NW-1:0]      num;
    logic [2:0][DRW-1:0]     drem;
    logic [2:0][NW-1:0]      quo;
  } stage_t;

  stage_t           st_q [0:LAST];
  stage_t           st_d [0:LAST];
  logic [LAST:0]    vld_q;
  logic             en;

  assign en         = out_o.ready || !out_o.valid;
  assign in_i.ready = en;

  // case selection and radicand
  logic signed [RB-1:0] m00, m11, m22, tr, rad_s;
  logic signed [DW:0]   m01, m02, m10, m12, m20, m21;
  logic signed [DW:0]   dl [3];
  case_e                sel;

  always_comb begin
    m00 = RB'(in_i.row0_col0);
    m11 = RB'(in_i.row1_col1);
    m22 = RB'(in_i.row2_col2);
    m01 = (DW+1)'(in_i.row0_col1);
    m02 = (DW+1)'(in_i.row0_col2);
    m10 = (DW+1)'(in_i.row1_col0);
    m12 = (DW+1)'(in_i.row1_col2);
    m20 = (DW+1)'(in_i.row2_col0);
    m21 = (DW+1)'(in_i.row2_col1);
    tr  = m00 + m11 + m22;
    priority if (!tr[RB-1]) begin
      sel   = CASE_TRACE;
      rad_s = tr + (RB'(1) << FRAC_BITS);
    end else if (m00 >= m11 && m00 >= m22) begin
      sel   = CASE_X;
      rad_s = m00 - (m11 + m22) + (RB'(1) << FRAC_BITS);
    end else if (m11 >= m22) begin
      sel   = CASE_Y;
      rad_s = m11 - (m22 + m00) + (RB'(1) << FRAC_BITS);
    end else begin
      sel   = CASE_Z;
      rad_s = m22 - (m00 + m11) + (RB'(1) << FRAC_BITS);
    end
    // lanes hold the non-diagonal components in x, y, z, w order
    unique case (sel)
      CASE_TRACE: begin
        dl[0] = m21 - m12;
        dl[1] = m02 - m20;
        dl[2] = m10 - m01;
      end
      CASE_X: begin
        dl[0] = m01 + m10;
        dl[1] = m20 + m02;
        dl[2] = m21 - m12;
      end
      CASE_Y: begin
        dl[0] = m01 + m10;
        dl[1] = m12 + m21;
        dl[2] = m02 - m20;
      end
      default: begin
        dl[0] = m20 + m02;
        dl[1] = m12 + m21;
        dl[2] = m10 - m01;
      end
    endcase
    st_d[0]      = '0;
    st_d[0].sel  = sel;
    st_d[0].bad  = rad_s[RB-1] || (rad_s == '0);
    st_d[0].rad  = RWE'({rad_s[RB-2:0], {FRAC_BITS{1'b0}}});
    for (int l = 0; l < 3; l++) begin
      st_d[0].neg[l] = dl[l][DW];
      st_d[0].num[l] = {(dl[l][DW] ? DW'(-dl[l]) : DW'(dl[l])) | {DW{1'b0}},
                        FRAC_BITS'(0)} | NW'(0);
      st_d[0].num[l][NW-1] = dl[l][DW] && (dl[l][DW-1:0] == '0);
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    logic [SRW-1:0] rem2, trial;
    always_comb begin
      rem2  = {st_q[i].srem[SRW-3:0], st_q[i].rad[RWE-1-2*i -: 2]};
      trial = SRW'({st_q[i].root, 2'b01});
      st_d[i+1] = st_q[i];
      if (rem2 >= trial) begin
        st_d[i+1].srem = rem2 - trial;
        st_d[i+1].root = {st_q[i].root[SQ-2:0], 1'b1};
      end else begin
        st_d[i+1].srem = rem2;
        st_d[i+1].root = {st_q[i].root[SQ-2:0], 1'b0};
      end
    end
  end

  // three dividers by 2*sqrt, one quotient bit per stage
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DRW-1:0] den;
    logic [DRW-1:0] dr2 [3];
    always_comb begin
      den = DRW'({st_q[SQ+j].root, 1'b0});
      st_d[SQ+j+1] = st_q[SQ+j];
      for (int l = 0; l < 3; l++) begin
        dr2[l] = {st_q[SQ+j].drem[l][DRW-2:0], st_q[SQ+j].num[l][NW-1-j]};
        if (dr2[l] >= den) begin
          st_d[SQ+j+1].drem[l] = dr2[l] - den;
          st_d[SQ+j+1].quo[l]  = {st_q[SQ+j].quo[l][NW-2:0], 1'b1};
        end else begin
          st_d[SQ+j+1].drem[l] = dr2[l];
          st_d[SQ+j+1].quo[l]  = {st_q[SQ+j].quo[l][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st_d[0];
      for (int s = 1; s <= LAST; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // output stage: place, sign and saturate, or zero all components on a bad radicand
  function automatic logic [DW-1:0] sat_f(input logic [MW-1:0] mag, input logic neg);
    logic [MW-1:0] lim;
    logic [MW-1:0] res;
    lim = MW'(1) << (DW - 1);
    if (!neg) begin
      res = (mag >= lim) ? lim - MW'(1) : mag;
    end else begin
      res = (mag >= lim) ? -lim : -mag;
    end
    return res[DW-1:0];
  endfunction

  logic [1:0]        diag;
  logic [1:0]        lane [4];
  logic [DW-1:0]     comp [4];
  stage_t            fin;

  always_comb begin
    fin  = st_q[LAST];
    diag = (fin.sel == CASE_TRACE) ? 2'd3 : 2'(fin.sel - CASE_X);
    for (int k = 0; k < 4; k++) begin
      lane[k] = (2'(k) < diag) ? 2'(k) : 2'(k - 1);
      if (fin.bad) begin
        comp[k] = '0;
      end else if (2'(k) == diag) begin
        comp[k] = sat_f(MW'(fin.root >> 1), 1'b0);
      end else begin
        comp[k] = sat_f(MW'(fin.quo[lane[k]]), fin.neg[lane[k]]);
      end
    end
  end

  logic                         out_vld_q;
  logic signed [DW-1:0]         qx_q, qy_q, qz_q, qw_q;
  logic [CASE_W-1:0]            case_q;
  logic                         bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q   <= comp[0];
      qy_q   <= comp[1];
      qz_q   <= comp[2];
      qw_q   <= comp[3];
      case_q <= fin.sel;
      bad_q  <= fin.bad;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.quat_x       = qx_q;
  assign out_o.quat_y       = qy_q;
  assign out_o.quat_z       = qz_q;
  assign out_o.quat_w       = qw_q;
  assign out_o.case_used    = case_q;
  assign out_o.bad_radicand = bad_q;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_radicand |->
      out_o.quat_x == '0 && out_o.quat_y == '0 && out_o.quat_z == '0 && out_o.quat_w == '0)
    else $error("bad radicand with nonzero components");
  a_bad_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_radicand |-> out_o.case_used != CASE_TRACE)
    else $error("bad radicand in trace case");
  a_trace_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.case_used == CASE_TRACE |-> !out_o.quat_w[DW-1])
    else $error("negative w in trace case");
`endif

endmodule
